// ----- sv/tss_pkg.sv -----
// tss_pkg: shared types and constants of the tiered signature scan block
// used by the channel interfaces and by tiered_signature_scan_top
package tss_pkg;

	localparam int unsigned DEFAULT_PREFIX_SCAN_BYTES = 32;

	localparam int unsigned COUNT_W = 33;
	localparam int unsigned BYTE_W = 8;
	localparam int unsigned HIST_W = 24;
	localparam int unsigned WIN_W = 32;
	localparam int unsigned MODE_W = 2;
	localparam int unsigned VERDICT_W = 2;

	localparam logic [WIN_W-1:0] SIG_NOP = 32'h9090_9090;
	localparam logic [WIN_W-1:0] SIG_INT3 = 32'hCCCC_CCCC;
	localparam logic [WIN_W-1:0] SIG_LOOP = 32'h0000_FEEB;

	localparam logic [COUNT_W-1:0] LIMIT_ENHANCED = 33'h0_4000_0000;
	localparam logic [COUNT_W-1:0] LIMIT_PARANOID = 33'h0_1000_0000;
	localparam logic [COUNT_W-1:0] MIN_WINDOW_COUNT = 33'd3;

	typedef enum logic [MODE_W-1:0] {
		MODE_DISABLED = 2'd0,
		MODE_BASIC = 2'd1,
		MODE_ENHANCED = 2'd2,
		MODE_PARANOID = 2'd3
	} mode_t;

	localparam mode_t MODE_RESET = MODE_ENHANCED;

	typedef enum logic [VERDICT_W-1:0] {
		VERDICT_PASS = 2'd0,
		VERDICT_EMPTY = 2'd1,
		VERDICT_TOO_LONG = 2'd2,
		VERDICT_SIGNATURE = 2'd3
	} verdict_t;

	typedef struct packed {
		logic passed;
		verdict_t verdict_code;
	} result_t;

	function automatic logic is_signature(input logic [WIN_W-1:0] window);
		return (window == SIG_NOP) || (window == SIG_INT3) || (window == SIG_LOOP);
	endfunction

endpackage

// ----- sv/tss_byte_if.sv -----
// tss_byte_if: valid/ready channel that carries one region byte request
// depends on tss_pkg
interface tss_byte_if import tss_pkg::*; ();

	logic valid;
	logic ready;
	logic [BYTE_W-1:0] data_byte;
	logic has_byte;
	logic end_of_region;

	modport source (output valid, output data_byte, output has_byte,
		output end_of_region, input ready);
	modport sink (input valid, input data_byte, input has_byte,
		input end_of_region, output ready);

endinterface

// ----- sv/tss_verdict_if.sv -----
// tss_verdict_if: valid/ready channel that carries one verdict request
// depends on tss_pkg
interface tss_verdict_if import tss_pkg::*; ();

	logic valid;
	logic ready;
	logic passed;
	logic [VERDICT_W-1:0] verdict_code;

	modport source (output valid, output passed, output verdict_code, input ready);
	modport sink (input valid, input passed, input verdict_code, output ready);

endinterface

// ----- sv/tiered_signature_scan_top.sv -----
// tiered_signature_scan_top: streams a region one byte per request, scans it for
// code signatures and gives one verdict per region; depends on tss_pkg,
// tss_byte_if and tss_verdict_if
//
// Usage: one byte request is taken every clock cycle while bytes.ready is high. The byte
// counter, the three-byte history and the signature window compare update in the cycle the
// request is accepted; the verdict of a request that ends a region is registered into the
// queue head, or into the skid entry when the head is full and not popped. Verdicts pass
// through a two-entry output queue, so bytes keep flowing while a verdict waits; the byte
// channel stalls only when two verdicts are waiting. The security mode resets to enhanced mode;
// the user must write it with cfg_we/cfg_wdata while the block is idle, not enforced by the block.
module tiered_signature_scan_top import tss_pkg::*; #(
	parameter int unsigned PREFIX_SCAN_BYTES = DEFAULT_PREFIX_SCAN_BYTES
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [MODE_W-1:0] cfg_wdata,
	tss_byte_if.sink bytes,
	tss_verdict_if.source verdict
);

	localparam logic [COUNT_W-1:0] PREFIX_COUNT = COUNT_W'(PREFIX_SCAN_BYTES);

	mode_t mode_q;
	logic [COUNT_W-1:0] count_q;
	logic [HIST_W-1:0] hist_q;
	logic seen_q;

	result_t head_q;
	result_t skid_q;
	logic head_valid_q;
	logic skid_valid_q;

	logic accept;
	logic take;
	logic push;
	logic pop;
	logic scan;
	logic hit;
	logic [COUNT_W-1:0] count_nx;
	logic [HIST_W-1:0] hist_nx;
	logic seen_nx;
	verdict_t code;
	result_t res;

	assign bytes.ready = !skid_valid_q;
	assign accept = bytes.valid && bytes.ready;
	assign take = accept && bytes.has_byte;
	assign push = accept && bytes.end_of_region;
	assign pop = head_valid_q && verdict.ready;

	// per-byte scan under the current mode
	always_comb begin
		unique case (mode_q)
			MODE_PARANOID: scan = 1'b1;
			MODE_ENHANCED: scan = count_q < PREFIX_COUNT;
			default: scan = 1'b0;
		endcase
		hit = scan && (count_q >= MIN_WINDOW_COUNT)
			&& is_signature({bytes.data_byte, hist_q});
	end

	always_comb begin
		count_nx = count_q;
		hist_nx = hist_q;
		seen_nx = seen_q;
		if (take) begin
			hist_nx = {bytes.data_byte, hist_q[HIST_W-1:BYTE_W]};
			seen_nx = seen_q || hit;
			if (!count_q[COUNT_W-1]) begin
				count_nx = count_q + COUNT_W'(1);
			end
		end
	end

	// verdict from the count and flag including the byte of this request
	always_comb begin
		unique case (mode_q)
			MODE_DISABLED: code = VERDICT_PASS;
			MODE_BASIC: begin
				priority if (count_nx == '0) code = VERDICT_EMPTY;
				else if (count_nx[COUNT_W-1]) code = VERDICT_TOO_LONG;
				else code = VERDICT_PASS;
			end
			MODE_ENHANCED: begin
				priority if (count_nx == '0) code = VERDICT_EMPTY;
				else if (count_nx > LIMIT_ENHANCED) code = VERDICT_TOO_LONG;
				else if (seen_nx) code = VERDICT_SIGNATURE;
				else code = VERDICT_PASS;
			end
			default: begin
				priority if (count_nx == '0) code = VERDICT_EMPTY;
				else if (count_nx > LIMIT_PARANOID) code = VERDICT_TOO_LONG;
				else if (seen_nx) code = VERDICT_SIGNATURE;
				else code = VERDICT_PASS;
			end
		endcase
		res.passed = (code == VERDICT_PASS);
		res.verdict_code = code;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_RESET;
		end else if (cfg_we) begin
			mode_q <= mode_t'(cfg_wdata);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			hist_q <= '0;
			seen_q <= 1'b0;
		end else if (push) begin
			count_q <= '0;
			hist_q <= '0;
			seen_q <= 1'b0;
		end else begin
			count_q <= count_nx;
			hist_q <= hist_nx;
			seen_q <= seen_nx;
		end
	end

	// two-entry verdict queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				if (skid_valid_q) begin
					skid_valid_q <= 1'b0;
				end else begin
					head_valid_q <= push;
				end
			end else if (push) begin
				if (head_valid_q) begin
					skid_valid_q <= 1'b1;
				end else begin
					head_valid_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && skid_valid_q) begin
			head_q <= skid_q;
		end else if (push && (pop || !head_valid_q)) begin
			head_q <= res;
		end
		if (push && head_valid_q && !pop) begin
			skid_q <= res;
		end
	end

	assign verdict.valid = head_valid_q;
	assign verdict.passed = head_q.passed;
	assign verdict.verdict_code = head_q.verdict_code;

endmodule

// ----- tb/tiered_signature_scan_top_tb.sv -----
// tiered_signature_scan_top_tb: self-checking regression of the tiered signature scan block,
// a directed table of regions followed by random regions checked against a verdict predictor
// depends on tss_pkg, tss_byte_if, tss_verdict_if and tiered_signature_scan_top
module tiered_signature_scan_top_tb import tss_pkg::*; ();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned SCAN_PREFIX = DEFAULT_PREFIX_SCAN_BYTES;
	localparam logic [COUNT_W-1:0] COUNT_CAP = 33'h1_0000_0000;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int HOLD_OFF_CYCLES = 150;
	localparam int PHASE_ITEMS = 150;
	localparam int NUM_PHASES = 12;
	localparam int PRESSURE_PHASE = 5;
	localparam int MAX_REPORTS = 10;

	typedef enum logic {ROW_ITEM, ROW_MODE} row_kind_t;

	typedef struct packed {
		row_kind_t kind;
		mode_t mode;
		logic [BYTE_W-1:0] data;
		logic has;
		logic eor;
		logic typed;
		verdict_t code;
	} stim_row_t;

	localparam int NUM_ROWS = 32;

	stim_row_t directed_rows [NUM_ROWS] = '{
		'{ROW_ITEM, MODE_ENHANCED, 8'h00, 1'b0, 1'b1, 1'b1, VERDICT_EMPTY},
		'{ROW_ITEM, MODE_ENHANCED, 8'hFF, 1'b0, 1'b0, 1'b0, VERDICT_PASS},
		'{ROW_ITEM, MODE_ENHANCED, 8'h90, 1'b1, 1'b0, 1'b0, VERDICT_PASS},
		'{ROW_ITEM, MODE_ENHANCED, 8'h90, 1'b1, 1'b0, 1'b0, VERDICT_PASS},
		'{ROW_ITEM, MODE_ENHANCED, 8'h90, 1'b1, 1'b1, 1'b1, VERDICT_PASS},
		'{ROW_ITEM, MODE_ENHANCED, 8'h90, 1'b1, 1'b0, 1'b0, VERDICT_PASS},
		'{ROW_ITEM, MODE_ENHANCED, 8'h90, 1'b1, 1'b0, 1'b0, VERDICT_PASS},
		'{ROW_ITEM, MODE_ENHANCED, 8'h90, 1'b1, 1'b0, 1'b0, VERDICT_PASS},
		'{ROW_ITEM, MODE_ENHANCED, 8'h90, 1'b1, 1'b1, 1'b1, VERDICT_SIGNATURE},
		'{ROW_MODE, MODE_PARANOID, 8'h00, 1'b0, 1'b0, 1'b0, VERDICT_PASS},
		'{ROW_ITEM, MODE_PARANOID, 8'h7F, 1'b1, 1'b0, 1'b0, VERDICT_PASS},
		'{ROW_ITEM, MODE_PARANOID, 8'hEB, 1'b1, 1'b0, 1'b0, VERDICT_PASS},
		'{ROW_ITEM, MODE_PARANOID, 8'hFE, 1'b1, 1'b0, 1'b0, VERDICT_PASS},
		'{ROW_ITEM, MODE_PARANOID, 8'h00, 1'b1, 1'b0, 1'b0, VERDICT_PASS},
		'{ROW_ITEM, MODE_PARANOID, 8'h00, 1'b1, 1'b1, 1'b0, VERDICT_PASS},
		'{ROW_MODE, MODE_DISABLED, 8'h00, 1'b0, 1'b0, 1'b0, VERDICT_PASS},
		'{ROW_ITEM, MODE_DISABLED, 8'h00, 1'b0, 1'b1, 1'b1, VERDICT_PASS},
		'{ROW_ITEM, MODE_DISABLED, 8'hCC, 1'b1, 1'b0, 1'b0, VERDICT_PASS},
		'{ROW_ITEM, MODE_DISABLED, 8'hCC, 1'b1, 1'b0, 1'b0, VERDICT_PASS},
		'{ROW_ITEM, MODE_DISABLED, 8'hCC, 1'b1, 1'b0, 1'b0, VERDICT_PASS},
		'{ROW_ITEM, MODE_DISABLED, 8'hCC, 1'b1, 1'b1, 1'b1, VERDICT_PASS},
		'{ROW_MODE, MODE_BASIC, 8'h00, 1'b0, 1'b0, 1'b0, VERDICT_PASS},
		'{ROW_ITEM, MODE_BASIC, 8'h00, 1'b0, 1'b1, 1'b1, VERDICT_EMPTY},
		'{ROW_ITEM, MODE_BASIC, 8'hFF, 1'b1, 1'b1, 1'b1, VERDICT_PASS},
		'{ROW_MODE, MODE_PARANOID, 8'h00, 1'b0, 1'b0, 1'b0, VERDICT_PASS},
		'{ROW_ITEM, MODE_PARANOID, 8'hCC, 1'b1, 1'b0, 1'b0, VERDICT_PASS},
		'{ROW_ITEM, MODE_PARANOID, 8'hCC, 1'b1, 1'b0, 1'b0, VERDICT_PASS},
		'{ROW_ITEM, MODE_PARANOID, 8'hCC, 1'b1, 1'b0, 1'b0, VERDICT_PASS},
		'{ROW_MODE, MODE_BASIC, 8'h00, 1'b0, 1'b0, 1'b0, VERDICT_PASS},
		'{ROW_ITEM, MODE_BASIC, 8'hCC, 1'b1, 1'b0, 1'b0, VERDICT_PASS},
		'{ROW_MODE, MODE_PARANOID, 8'h00, 1'b0, 1'b0, 1'b0, VERDICT_PASS},
		'{ROW_ITEM, MODE_PARANOID, 8'h00, 1'b0, 1'b1, 1'b0, VERDICT_PASS}
	};

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [MODE_W-1:0] cfg_wdata;

	tss_byte_if byte_ch ();
	tss_verdict_if verdict_ch ();

	tiered_signature_scan_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.bytes(byte_ch),
		.verdict(verdict_ch)
	);

	// predictor state
	mode_t scan_mode;
	logic [COUNT_W-1:0] region_len;
	logic [HIST_W-1:0] byte_history;
	logic sig_hit;

	result_t expected_verdicts [$];
	int verdict_errors;
	int stim_items;
	int idle_cycles;
	logic tx_gaps;
	logic rx_gaps;
	logic hold_request;

	initial clk = 1'b0;
	always #4 clk = ~clk;

	function automatic logic predict_region_verdict(input logic [BYTE_W-1:0] b, input logic has,
		input logic eor, output verdict_t code);
		logic [WIN_W-1:0] window;
		logic scan;
		code = VERDICT_PASS;
		if (has) begin
			scan = (scan_mode == MODE_PARANOID) ||
				(scan_mode == MODE_ENHANCED && region_len < SCAN_PREFIX);
			window = {b, byte_history};
			if (scan && region_len >= 3 &&
				(window == SIG_NOP || window == SIG_INT3 || window == SIG_LOOP))
				sig_hit = 1'b1;
			byte_history = {b, byte_history[HIST_W-1:8]};
			if (region_len < COUNT_CAP)
				region_len = region_len + 1'b1;
		end
		if (!eor)
			return 1'b0;
		case (scan_mode)
			MODE_DISABLED: code = VERDICT_PASS;
			MODE_BASIC: begin
				if (region_len == 0) code = VERDICT_EMPTY;
				else if (region_len >= COUNT_CAP) code = VERDICT_TOO_LONG;
				else code = VERDICT_PASS;
			end
			MODE_ENHANCED: begin
				if (region_len == 0) code = VERDICT_EMPTY;
				else if (region_len > LIMIT_ENHANCED) code = VERDICT_TOO_LONG;
				else code = sig_hit ? VERDICT_SIGNATURE : VERDICT_PASS;
			end
			default: begin
				if (region_len == 0) code = VERDICT_EMPTY;
				else if (region_len > LIMIT_PARANOID) code = VERDICT_TOO_LONG;
				else code = sig_hit ? VERDICT_SIGNATURE : VERDICT_PASS;
			end
		endcase
		region_len = '0;
		byte_history = '0;
		sig_hit = 1'b0;
		return 1'b1;
	endfunction

	task automatic report_error(input string what, input int exp_v, input int act_v);
		verdict_errors++;
		if (verdict_errors <= MAX_REPORTS)
			$display("%0t: %s: expected %0d, got %0d", $realtime, what, exp_v, act_v);
	endtask

	// called at a falling edge, returns at the falling edge after the request is taken
	task automatic send_item(input logic [BYTE_W-1:0] d, input logic h, input logic e,
		input logic typed = 1'b0, input verdict_t typed_code = VERDICT_PASS);
		int gap;
		verdict_t code;
		gap = tx_gaps ? $urandom_range(0, 9) : 0;
		if (gap > 0) begin
			byte_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		byte_ch.valid <= 1'b1;
		byte_ch.data_byte <= d;
		byte_ch.has_byte <= h;
		byte_ch.end_of_region <= e;
		do @(posedge clk); while (!byte_ch.ready);
		if (h || e)
			stim_items++;
		if (predict_region_verdict(d, h, e, code)) begin
			if (typed)
				code = typed_code;
			expected_verdicts.push_back(result_t'{code == VERDICT_PASS, code});
		end
		@(negedge clk);
	endtask

	task automatic write_mode(input mode_t m);
		byte_ch.valid <= 1'b0;
		while (expected_verdicts.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= m;
		@(negedge clk);
		cfg_we <= 1'b0;
		scan_mode = m;
	endtask

	function automatic logic [BYTE_W-1:0] pick_byte();
		case ($urandom_range(0, 7))
			0: return 8'h90;
			1: return 8'hCC;
			2: return 8'h00;
			3: return 8'hEB;
			4: return 8'hFE;
			default: return BYTE_W'($urandom);
		endcase
	endfunction

	task automatic send_region();
		int len;
		int r;
		int pos;
		logic split;
		logic [WIN_W-1:0] sig;
		logic [BYTE_W-1:0] body [];
		r = $urandom_range(0, 99);
		if (r < 5) len = 0;
		else if (r < 15) len = $urandom_range(1, 3);
		else if (r < 97) len = $urandom_range(4, 40);
		else len = $urandom_range(100, 300);
		body = new[len];
		foreach (body[i])
			body[i] = pick_byte();
		if (len >= 4 && $urandom_range(0, 1) == 1) begin
			case ($urandom_range(0, 2))
				0: sig = SIG_NOP;
				1: sig = SIG_INT3;
				default: sig = SIG_LOOP;
			endcase
			pos = $urandom_range(0, len - 4);
			for (int k = 0; k < 4; k++)
				body[pos + k] = sig[8*k +: 8];
		end
		split = (len == 0) || ($urandom_range(0, 2) == 0);
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(0, 15) == 0)
				send_item(BYTE_W'($urandom), 1'b0, 1'b0);
			send_item(body[i], 1'b1, !split && i == len - 1);
		end
		if (split)
			send_item(BYTE_W'($urandom), 1'b0, 1'b1);
	endtask

	// verdict receiver
	initial begin
		int stall;
		result_t want;
		verdict_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			if (hold_request) begin
				hold_request = 1'b0;
				stall = HOLD_OFF_CYCLES;
			end else begin
				stall = rx_gaps ? $urandom_range(0, 9) : 0;
			end
			if (stall > 0) begin
				verdict_ch.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			verdict_ch.ready <= 1'b1;
			do @(posedge clk); while (!verdict_ch.valid);
			if (expected_verdicts.size() == 0) begin
				report_error("verdict with none pending", -1, verdict_ch.verdict_code);
			end else begin
				want = expected_verdicts.pop_front();
				if (verdict_ch.passed !== want.passed)
					report_error("passed", want.passed, verdict_ch.passed);
				if (verdict_ch.verdict_code !== want.verdict_code)
					report_error("verdict_code", want.verdict_code, verdict_ch.verdict_code);
			end
			@(negedge clk);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (byte_ch.valid && byte_ch.ready) || (verdict_ch.valid && verdict_ch.ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("tiered_signature_scan_top regression: fail");
				$finish;
			end
		end
	end

	initial begin
		int start;
		mode_t m;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = MODE_RESET;
		byte_ch.valid = 1'b0;
		byte_ch.data_byte = '0;
		byte_ch.has_byte = 1'b0;
		byte_ch.end_of_region = 1'b0;
		scan_mode = MODE_RESET;
		region_len = '0;
		byte_history = '0;
		sig_hit = 1'b0;
		verdict_errors = 0;
		stim_items = 0;
		idle_cycles = 0;
		tx_gaps = 1'b1;
		rx_gaps = 1'b1;
		hold_request = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed_rows[i]) begin
			if (directed_rows[i].kind == ROW_MODE)
				write_mode(directed_rows[i].mode);
			else
				send_item(directed_rows[i].data, directed_rows[i].has, directed_rows[i].eor,
					directed_rows[i].typed, directed_rows[i].code);
		end

		for (int p = 0; p < NUM_PHASES; p++) begin
			case (p)
				0: m = MODE_DISABLED;
				1: m = MODE_PARANOID;
				2: m = MODE_BASIC;
				3: m = MODE_ENHANCED;
				default: m = mode_t'($urandom_range(0, 3));
			endcase
			write_mode(m);
			tx_gaps = $urandom_range(0, 3) != 0;
			rx_gaps = $urandom_range(0, 3) != 0;
			start = stim_items;
			if (p == PRESSURE_PHASE) begin
				// receiver holds off while short regions keep coming back to back
				tx_gaps = 1'b0;
				hold_request = 1'b1;
				repeat (30)
					send_item(BYTE_W'($urandom), 1'($urandom_range(0, 1)), 1'b1);
				tx_gaps = 1'b1;
			end
			while (stim_items - start < PHASE_ITEMS)
				send_region();
		end

		byte_ch.valid <= 1'b0;
		while (expected_verdicts.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (expected_verdicts.size() != 0)
			report_error("verdicts left pending", 0, expected_verdicts.size());
		if (verdict_errors == 0)
			$display("tiered_signature_scan_top regression: pass");
		else
			$display("tiered_signature_scan_top regression: fail");
		$finish;
	end

endmodule
